/* rtl/gbds_pkg.sv */
package gbds_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_IY, ST_IX, ST_CY, ST_CX, ST_BASE,
    ST_R0, ST_R1, ST_R2, ST_R3, ST_R4,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_DOP, ST_DW, ST_DC, ST_FIN
  } state_t;

  typedef enum logic [1:0] {OFS_ZERO, OFS_PLUS, OFS_MINUS} ofs_t;

  typedef enum logic [2:0] {
    DOP_GX, DOP_GY, DOP_XX1, DOP_XX2, DOP_YY1, DOP_YY2, DOP_XY1, DOP_XY2
  } der_op_t;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_INV_CELL = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;
  localparam logic [2:0] REG_INV_SX   = 3'd5;
  localparam logic [2:0] REG_INV_SY   = 3'd6;

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_QUERY = 1'b1;

  localparam logic [3:0] LAST_SAMPLE = 4'd8;

  localparam logic signed [65:0] PROD_LIM   = 66'sh3FFFFFFFFFFF;
  localparam logic signed [65:0] SAMPLE_LIM = 66'shFFFFFFFFFFF;

  function automatic ofs_t x_ofs(input logic [3:0] k);
    ofs_t o;
    unique case (k)
      4'd1, 4'd5, 4'd6: o = OFS_PLUS;
      4'd2, 4'd7, 4'd8: o = OFS_MINUS;
      default:          o = OFS_ZERO;
    endcase
    return o;
  endfunction

  function automatic ofs_t y_ofs(input logic [3:0] k);
    ofs_t o;
    unique case (k)
      4'd3, 4'd5, 4'd7: o = OFS_PLUS;
      4'd4, 4'd6, 4'd8: o = OFS_MINUS;
      default:          o = OFS_ZERO;
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh7FFFFFFF)
      r = 32'sh7FFFFFFF;
    else if (v < -48'sh80000000)
      r = -32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [45:0] v);
    logic signed [15:0] r;
    if (v > 46'sh7FFF)
      r = 16'sh7FFF;
    else if (v < -46'sh8000)
      r = -16'sh8000;
    else
      r = v[15:0];
    return r;
  endfunction

endpackage

/* rtl/grid_bilinear_derivative_sampler.sv */
// Grid sampler: bilinear value, gradient and Hessian over a stored Q8.8 grid.
// Input channel (in_valid/in_ready): req_type 0 writes cell_value at
// cell_row/cell_col (out of range writes are dropped); req_type 1
// queries the point query_x/query_y and yields one result on the output
// channel (out_valid/out_ready). Config channel (cfg_valid/cfg_ready) writes
// the register picked by cfg_index; it is always ready and is meant to be
// used while no query is in flight.
// A query runs nine samples through states IY to P5 (two index multiplies
// through the shared Q16.16 multiplier, four reads of the single-port grid
// RAM, the row and column interpolation), then eight passes of DOP, DW and
// DC through the same multiplier for the derivatives, and FIN to load the
// output register. One item is worked on at a time; in_ready is high only
// while idle, so a new query or write is taken only after the last query
// has loaded its result.
// Reset clears the control state and loads the default registers; grid
// contents are undefined until written. When the receiver stalls, the result
// sits in the output register and a finished next query waits for it.
module grid_bilinear_derivative_sampler
  import gbds_pkg::*;
#(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [6:0]         cell_row,
  input  logic [6:0]         cell_col,
  input  logic signed [15:0] cell_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_value,
  output logic signed [31:0] grad_x,
  output logic signed [31:0] grad_y,
  output logic signed [31:0] hess_xx,
  output logic signed [31:0] hess_yy,
  output logic signed [31:0] hess_xy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam logic signed [31:0] ROW_MAX = 32'((GRID_ROWS - 2) * 65536);
  localparam logic signed [31:0] COL_MAX = 32'((GRID_COLS - 2) * 65536);
  localparam logic [AW-1:0] COLS_A = AW'(GRID_COLS);

  state_t state, state_next;

  logic signed [31:0] org_x, org_y;
  logic [31:0]        inv_cell, inv_sx, inv_sy;
  logic [30:0]        stp_x, stp_y;
  logic signed [31:0] qx, qy;
  logic [3:0]         k;
  der_op_t            dk;

  logic signed [31:0] iy_r, ix_c;
  logic [RW-1:0]      i0_c, i0_r;
  logic [CW-1:0]      j0_c, j0_r;
  logic signed [33:0] wi, wj, wi_c, wj_c;
  logic [AW-1:0]      base;
  logic signed [15:0] f00, f10, f01, f11;
  logic signed [50:0] rp;
  logic signed [44:0] f0, f1;
  logic signed [45:0] dd;
  logic signed [63:0] ph;
  logic signed [62:0] pl;
  logic signed [65:0] samp_sum;
  logic signed [44:0] smp [9];
  logic signed [46:0] dres [8];

  logic signed [34:0] cx, cy;
  logic signed [47:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [46:0] mul_res;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic signed [15:0] ram_rdata;
  logic               wr_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign wr_ok     = (32'(cell_row) < GRID_ROWS) && (32'(cell_col) < GRID_COLS);
  assign ram_we    = (state == ST_IDLE) && in_valid && (req_type == REQ_WRITE) && wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x    <= '0;
      org_y    <= '0;
      inv_cell <= 32'd65536;
      stp_x    <= 31'd65536;
      stp_y    <= 31'd65536;
      inv_sx   <= 32'd65536;
      inv_sy   <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: org_x    <= cfg_data;
        REG_ORIGIN_Y: org_y    <= cfg_data;
        REG_INV_CELL: inv_cell <= cfg_data;
        REG_STEP_X:   stp_x    <= cfg_data[30:0];
        REG_STEP_Y:   stp_y    <= cfg_data[30:0];
        REG_INV_SX:   inv_sx   <= cfg_data;
        REG_INV_SY:   inv_sy   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample point relative to the grid origin
  always_comb begin
    unique case (x_ofs(k))
      OFS_PLUS:  cx = 35'(qx) + 35'($signed({1'b0, stp_x})) - 35'(org_x);
      OFS_MINUS: cx = 35'(qx) - 35'($signed({1'b0, stp_x})) - 35'(org_x);
      default:   cx = 35'(qx) - 35'(org_x);
    endcase
    unique case (y_ofs(k))
      OFS_PLUS:  cy = 35'(qy) + 35'($signed({1'b0, stp_y})) - 35'(org_y);
      OFS_MINUS: cy = 35'(qy) - 35'($signed({1'b0, stp_y})) - 35'(org_y);
      default:   cy = 35'(qy) - 35'(org_y);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_IY: begin
        mul_a = 48'(cy);
        mul_b = inv_cell;
      end
      ST_IX: begin
        mul_a = 48'(cx);
        mul_b = inv_cell;
      end
      ST_DOP: begin
        unique case (dk)
          DOP_GX: begin
            mul_a = 48'(smp[1]) - 48'(smp[2]);
            mul_b = inv_sx;
          end
          DOP_GY: begin
            mul_a = 48'(smp[3]) - 48'(smp[4]);
            mul_b = inv_sy;
          end
          DOP_XX1: begin
            mul_a = 48'(smp[1]) + 48'(smp[2]) - (48'(smp[0]) <<< 1);
            mul_b = inv_sx;
          end
          DOP_XX2: begin
            mul_a = 48'(dres[DOP_XX1]);
            mul_b = inv_sx;
          end
          DOP_YY1: begin
            mul_a = 48'(smp[3]) + 48'(smp[4]) - (48'(smp[0]) <<< 1);
            mul_b = inv_sy;
          end
          DOP_YY2: begin
            mul_a = 48'(dres[DOP_YY1]);
            mul_b = inv_sy;
          end
          DOP_XY1: begin
            mul_a = 48'(smp[5]) + 48'(smp[8]) - 48'(smp[6]) - 48'(smp[7]);
            mul_b = inv_sx;
          end
          DOP_XY2: begin
            mul_a = 48'(dres[DOP_XY1]);
            mul_b = inv_sy;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  gbds_mulq u_mulq (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_res)
  );

  // corner cell and weights
  always_comb begin
    ix_c = sat32(48'(mul_res));
    if (iy_r[31])
      i0_c = '0;
    else if (iy_r > ROW_MAX)
      i0_c = RW'(GRID_ROWS - 2);
    else
      i0_c = iy_r[16+RW-1:16];
    if (ix_c[31])
      j0_c = '0;
    else if (ix_c > COL_MAX)
      j0_c = CW'(GRID_COLS - 2);
    else
      j0_c = ix_c[16+CW-1:16];
    wi_c = 34'(iy_r) - $signed({{(18-RW){1'b0}}, i0_c, 16'b0});
    wj_c = 34'(ix_c) - $signed({{(18-CW){1'b0}}, j0_c, 16'b0});
    samp_sum = 66'(f0) + 66'(ph) + ((66'(pl) + 66'sd32768) >>> 16);
  end

  always_comb begin
    unique case (state)
      ST_R0:   ram_addr = base;
      ST_R1:   ram_addr = base + COLS_A;
      ST_R2:   ram_addr = base + AW'(1);
      ST_R3:   ram_addr = base + COLS_A + AW'(1);
      default: ram_addr = AW'(32'(cell_row) * GRID_COLS + 32'(cell_col));
    endcase
  end

  gbds_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cell_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        qx <= query_x;
        qy <= query_y;
      end
      ST_CY: iy_r <= sat32(48'(mul_res));
      ST_CX: begin
        i0_r <= i0_c;
        j0_r <= j0_c;
        wi   <= wi_c;
        wj   <= wj_c;
      end
      ST_BASE: base <= AW'(32'(i0_r) * GRID_COLS + 32'(j0_r));
      ST_R1: f00 <= ram_rdata;
      ST_R2: f10 <= ram_rdata;
      ST_R3: begin
        f01 <= ram_rdata;
        rp  <= 51'(wi) * 51'(17'(f10) - 17'(f00));
      end
      ST_R4: begin
        f11 <= ram_rdata;
        f0  <= 45'(((52'(f00) <<< 16) + 52'(rp) + 52'sd128) >>> 8);
      end
      ST_P1: rp <= 51'(wi) * 51'(17'(f11) - 17'(f01));
      ST_P2: f1 <= 45'(((52'(f01) <<< 16) + 52'(rp) + 52'sd128) >>> 8);
      ST_P3: dd <= 46'(f1) - 46'(f0);
      ST_P4: begin
        ph <= 64'(wj >>> 16) * 64'(dd);
        pl <= 63'($signed({1'b0, wj[15:0]})) * 63'(dd);
      end
      ST_P5: begin
        if (samp_sum > SAMPLE_LIM)
          smp[k] <= 45'(SAMPLE_LIM);
        else if (samp_sum < -SAMPLE_LIM)
          smp[k] <= 45'(-SAMPLE_LIM);
        else
          smp[k] <= samp_sum[44:0];
      end
      ST_DC: dres[dk] <= mul_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      sample_value <= sat16((46'(smp[0]) + 46'sd128) >>> 8);
      grad_x       <= sat32((48'(dres[DOP_GX]) + 48'sd1) >>> 1);
      grad_y       <= sat32((48'(dres[DOP_GY]) + 48'sd1) >>> 1);
      hess_xx      <= sat32(48'(dres[DOP_XX2]));
      hess_yy      <= sat32(48'(dres[DOP_YY2]));
      hess_xy      <= sat32((48'(dres[DOP_XY2]) + 48'sd2) >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      dk        <= DOP_GX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE)
        k <= '0;
      else if (state == ST_P5 && k != LAST_SAMPLE)
        k <= k + 4'd1;
      if (state == ST_P5)
        dk <= DOP_GX;
      else if (state == ST_DC)
        dk <= der_op_t'(dk + 3'd1);
      if (state == ST_FIN && (!out_valid || out_ready))
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && req_type == REQ_QUERY) state_next = ST_IY;
      ST_IY:   state_next = ST_IX;
      ST_IX:   state_next = ST_CY;
      ST_CY:   state_next = ST_CX;
      ST_CX:   state_next = ST_BASE;
      ST_BASE: state_next = ST_R0;
      ST_R0:   state_next = ST_R1;
      ST_R1:   state_next = ST_R2;
      ST_R2:   state_next = ST_R3;
      ST_R3:   state_next = ST_R4;
      ST_R4:   state_next = ST_P1;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_P4;
      ST_P4:   state_next = ST_P5;
      ST_P5:   state_next = (k == LAST_SAMPLE) ? ST_DOP : ST_IY;
      ST_DOP:  state_next = ST_DW;
      ST_DW:   state_next = ST_DC;
      ST_DC:   state_next = (dk == DOP_XY2) ? ST_FIN : ST_DOP;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !ram_we)
    else $error("grid written while a query is in flight");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_QUERY) |=> !in_ready)
    else $error("input still ready after query transfer");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the final step");
`endif

endmodule

/* rtl/gbds_grid_ram.sv */
module gbds_grid_ram
  import gbds_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic signed [15:0] wdata,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/gbds_mulq.sv */
module gbds_mulq
  import gbds_pkg::*;
(
  input  logic               clk,
  input  logic signed [47:0] a,
  input  logic [31:0]        b,
  output logic signed [46:0] p
);

  logic signed [47:0] a_r;
  logic [15:0]        bh_r;
  logic signed [64:0] pl_r;
  logic signed [65:0] hi;
  logic signed [65:0] sum;

  always_ff @(posedge clk) begin
    a_r  <= a;
    bh_r <= b[31:16];
    pl_r <= 65'(a) * 65'($signed({1'b0, b[15:0]}));
  end

  always_comb begin
    hi  = 66'(a_r) * 66'($signed({1'b0, bh_r}));
    sum = hi + ((66'(pl_r) + 66'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (sum > PROD_LIM)
      p <= 47'(PROD_LIM);
    else if (sum < -PROD_LIM)
      p <= 47'(-PROD_LIM);
    else
      p <= sum[46:0];
  end

endmodule
